// File: hw/rtl/lcd_mts_pkg.sv
// Shared constants, register indexes and controller/datapath types for the LCD mode sequencer.
package lcd_mts_pkg;

  localparam int unsigned PERIOD_W   = 10;
  localparam int unsigned LINE_W     = 8;
  localparam int unsigned ACC_W      = 11;
  localparam int unsigned ELAPSED_W  = 8;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // remainder unit: 6 quotient bits per cycle over a 12-bit padded dividend
  localparam int unsigned DIV_BITS   = 6;
  localparam int unsigned DIV_STEPS  = 2;
  localparam int unsigned DIVIDEND_W = DIV_BITS * DIV_STEPS;
  localparam int unsigned STEP_W     = 1;

  localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_VRAM   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_OAM_CYCLES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VRAM_CYCLES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HBLANK_CYCLES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VBLANK_CYCLES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_LINES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LINES   = 3'd5;

  localparam logic [PERIOD_W-1:0] RST_OAM_CYCLES    = 10'd80;
  localparam logic [PERIOD_W-1:0] RST_VRAM_CYCLES   = 10'd172;
  localparam logic [PERIOD_W-1:0] RST_HBLANK_CYCLES = 10'd204;
  localparam logic [PERIOD_W-1:0] RST_VBLANK_CYCLES = 10'd456;
  localparam logic [LINE_W-1:0]   RST_VISIBLE_LINES = 8'd144;
  localparam logic [LINE_W-1:0]   RST_TOTAL_LINES   = 8'd154;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

// File: hw/rtl/lcd_mts_if.sv
// Request and result channel interfaces of the LCD mode sequencer.
interface lcd_mts_in_if import lcd_mts_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed_cycles;

  modport source (output valid, output elapsed_cycles, input ready);
  modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

interface lcd_mts_out_if import lcd_mts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] display_mode;
  logic [LINE_W-1:0] current_line;
  logic              vblank_request;
  logic              render_strobe;

  modport source (output valid, output display_mode, output current_line,
                  output vblank_request, output render_strobe, input ready);
  modport sink   (input valid, input display_mode, input current_line,
                  input vblank_request, input render_strobe, output ready);
endinterface

// File: hw/rtl/lcd_mode_timing_sequencer.sv
// Top level of the LCD mode timing sequencer.
// Sequence: an accepted request is loaded, two remainder steps of 6 bits each
// run, then the commit registers the result; a stalled result holds off the commit.
// A new request is taken only after the previous one has committed (iterative remainder unit).
// Reset: asynchronous active low; OAM scan, line 0, accumulator 0, default periods.
module lcd_mode_timing_sequencer import lcd_mts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  lcd_mts_in_if.sink            item_i,
  lcd_mts_out_if.source         result_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  lcd_mts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcd_mts_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .elapsed_i   (item_i.elapsed_cycles),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .mode_o      (result_o.display_mode),
    .line_o      (result_o.current_line),
    .vreq_o      (result_o.vblank_request),
    .strobe_o    (result_o.render_strobe)
  );

endmodule

// File: hw/rtl/lcd_mts_ctrl.sv
// Controller state machine: request accept, remainder steps and state commit.
module lcd_mts_ctrl import lcd_mts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIV    = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/lcd_mts_dp.sv
// Datapath: config registers, mode/line/accumulator state, remainder unit, result register.
module lcd_mts_dp import lcd_mts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [ELAPSED_W-1:0]  elapsed_i,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [MODE_W-1:0]     mode_o,
  output logic [LINE_W-1:0]     line_o,
  output logic                  vreq_o,
  output logic                  strobe_o
);

  logic [PERIOD_W-1:0]   oam_q, vram_q, hblank_q, vblank_q;
  logic [LINE_W-1:0]     visible_q, total_q;

  logic [MODE_W-1:0]     mode_q, mode_d;
  logic [LINE_W-1:0]     line_q, line_d;
  logic [ACC_W-1:0]      acc_q, acc_d;

  logic [PERIOD_W-1:0]   period_q, period_sel;
  logic [PERIOD_W-1:0]   rem_q, rem_d;
  logic [DIVIDEND_W-1:0] shf_q, shf_d;
  logic                  hit_q, hit_d;

  logic [ACC_W-1:0]      sum;
  logic [LINE_W-1:0]     line_inc;
  logic                  vreq_d, strobe_d;

  logic                  out_valid_q;
  logic [MODE_W-1:0]     out_mode_q;
  logic [LINE_W-1:0]     out_line_q;
  logic                  out_vreq_q, out_strobe_q;

  assign sum = acc_q + ACC_W'(elapsed_i);

  // zero period behaves as one
  always_comb begin
    case (mode_q)
      MODE_HBLANK: period_sel = hblank_q;
      MODE_VBLANK: period_sel = vblank_q;
      MODE_OAM:    period_sel = oam_q;
      default:     period_sel = vram_q;
    endcase
    if (period_sel == '0) begin
      period_sel = PERIOD_W'(1);
    end
  end

  // restoring remainder, DIV_BITS bits per step
  always_comb begin
    logic [PERIOD_W:0] trial;
    rem_d = rem_q;
    shf_d = shf_q;
    hit_d = hit_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_d, shf_d[DIVIDEND_W-1]};
      shf_d = shf_d << 1;
      if (trial >= {1'b0, period_q}) begin
        trial = trial - {1'b0, period_q};
        hit_d = 1'b1;
      end
      rem_d = trial[PERIOD_W-1:0];
    end
  end

  assign line_inc = line_q + LINE_W'(1);

  always_comb begin
    mode_d   = mode_q;
    line_d   = line_q;
    acc_d    = hit_q ? ACC_W'(rem_q) : acc_q;
    vreq_d   = 1'b0;
    strobe_d = 1'b0;
    if (hit_q) begin
      case (mode_q)
        MODE_HBLANK: begin
          line_d = line_inc;
          if (line_inc == visible_q) begin
            mode_d = MODE_VBLANK;
            vreq_d = 1'b1;
          end else begin
            mode_d = MODE_OAM;
          end
        end
        MODE_VBLANK: begin
          if (line_inc >= total_q) begin
            mode_d = MODE_OAM;
            line_d = '0;
          end else begin
            line_d = line_inc;
          end
        end
        MODE_OAM: begin
          mode_d = MODE_VRAM;
        end
        default: begin
          mode_d   = MODE_HBLANK;
          strobe_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oam_q     <= RST_OAM_CYCLES;
      vram_q    <= RST_VRAM_CYCLES;
      hblank_q  <= RST_HBLANK_CYCLES;
      vblank_q  <= RST_VBLANK_CYCLES;
      visible_q <= RST_VISIBLE_LINES;
      total_q   <= RST_TOTAL_LINES;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OAM_CYCLES:    oam_q     <= cfg_data_i;
        REG_VRAM_CYCLES:   vram_q    <= cfg_data_i;
        REG_HBLANK_CYCLES: hblank_q  <= cfg_data_i;
        REG_VBLANK_CYCLES: vblank_q  <= cfg_data_i;
        REG_VISIBLE_LINES: visible_q <= cfg_data_i[LINE_W-1:0];
        REG_TOTAL_LINES:   total_q   <= cfg_data_i[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_OAM;
      line_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        acc_q <= sum;
      end else if (cmd_i.commit) begin
        mode_q <= mode_d;
        line_q <= line_d;
        acc_q  <= acc_d;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      period_q <= period_sel;
      rem_q    <= '0;
      shf_q    <= DIVIDEND_W'(sum);
      hit_q    <= 1'b0;
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      shf_q <= shf_d;
      hit_q <= hit_d;
    end
    if (cmd_i.commit) begin
      out_mode_q   <= mode_d;
      out_line_q   <= line_d;
      out_vreq_q   <= vreq_d;
      out_strobe_q <= strobe_d;
    end
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign mode_o         = out_mode_q;
  assign line_o         = out_line_q;
  assign vreq_o         = out_vreq_q;
  assign strobe_o       = out_strobe_q;

endmodule

// File: hw/rtl/lcd_mts_chk.sv
// Port-level assertion checker for the LCD mode timing sequencer, with its bind.
module lcd_mts_chk import lcd_mts_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [MODE_W-1:0] mode_i,
  input logic              vreq_i,
  input logic              strobe_i
);

  // interrupt request only on entering vertical blank
  a_vreq_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && vreq_i |-> mode_i == MODE_VBLANK)
    else $error("vblank request outside vertical blank");

  // render strobe only on entering horizontal blank
  a_strobe_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && strobe_i |-> mode_i == MODE_HBLANK)
    else $error("render strobe outside horizontal blank");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request accepted while previous one in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(mode_i) && $stable(vreq_i) && $stable(strobe_i))
    else $error("stalled result changed");

endmodule

bind lcd_mode_timing_sequencer lcd_mts_chk u_lcd_mts_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .mode_i      (result_o.display_mode),
  .vreq_i      (result_o.vblank_request),
  .strobe_i    (result_o.render_strobe)
);
